// ===== src/fbba_pkg.sv =====
`timescale 1ns / 1ps

package fbba_pkg;

   localparam int NUM_WORDS_DEF     = 8;
   localparam int BUF_SIZE_LOG2_DEF = 11;
   localparam int WORD_BITS         = 32;
   localparam int BIT_IDX_W         = 5;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_FULL      = 2'd2,
      ST_OUTSIDE   = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;      // latch request fields, clear result
      logic       rd_free;      // read the word addressed by the free request
      logic       rd_first;     // read bitmap word 0
      logic       rd_next;      // read the word after the one last read
      logic       claim;        // set lowest free bit of the word just read
      logic       free_wr;      // clear the addressed bit of the word just read
      logic       set_status;
      status_type status_code;
      logic       rsp_load;     // move result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_free_op;
      logic too_large;
      logic outside;
      logic word_has_free;
      logic last_word;
      logic out_slot_free;
   } sts_type;

endpackage

// ===== src/fbba_ctrl.sv =====
`timescale 1ns / 1ps

module fbba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fbba_pkg::sts_type sts,
   output fbba_pkg::cmd_type cmd
);
   import fbba_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_START   = 6'b000010,
      S_SCAN    = 6'b000100,
      S_CLAIM   = 6'b001000,
      S_FREE_WR = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            if (sts.is_free_op) begin
               if (sts.outside) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_OUTSIDE;
                  state_in        = S_DONE;
               end else begin
                  cmd.rd_free = 1'b1;
                  state_in    = S_FREE_WR;
               end
            end else if (sts.too_large) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_TOO_LARGE;
               state_in        = S_DONE;
            end else begin
               cmd.rd_first = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (sts.word_has_free) begin
               state_in = S_CLAIM;
            end else if (sts.last_word) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_FULL;
               state_in        = S_DONE;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_CLAIM: begin
            cmd.claim = 1'b1;
            state_in  = S_DONE;
         end
         S_FREE_WR: begin
            cmd.free_wr = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (sts.out_slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/fbba_datapath.sv =====
`timescale 1ns / 1ps

module fbba_datapath #(
   parameter int NUM_WORDS     = fbba_pkg::NUM_WORDS_DEF,
   parameter int BUF_SIZE_LOG2 = fbba_pkg::BUF_SIZE_LOG2_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_op,
   input  logic [15:0]       req_request_bytes,
   input  logic [31:0]       req_buffer_address,
   input  logic              csr_write,
   input  logic [31:0]       csr_pool_base,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_granted_address,
   input  fbba_pkg::cmd_type cmd,
   output fbba_pkg::sts_type sts
);
   import fbba_pkg::*;

   localparam int WW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int HI_LO = BUF_SIZE_LOG2 + BIT_IDX_W;
   localparam int HI_W  = 32 - HI_LO;

   // request and configuration registers
   logic             op_ff;
   logic [15:0]      req_bytes_ff;
   logic [31:0]      addr_ff;
   logic [31:0]      pool_base_ff;

   // bitmap memory, one valid bit per word stands for the reset value
   logic [WORD_BITS-1:0] use_mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] word_valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_live_ff;
   logic [WW-1:0]        rd_idx_ff;
   logic [WW-1:0]        rd_addr;
   logic                 rd_en;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] cur_word;

   // result and output registers
   status_type  res_status_ff;
   logic [31:0] res_granted_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_granted_ff;

   logic [32:0]          diff;
   logic                 outside;
   logic [WW-1:0]        free_word;
   logic [BIT_IDX_W-1:0] free_addr_bit;
   logic [BIT_IDX_W-1:0] claim_bit;
   logic [31:0]          grant_off;
   logic [31:0]          granted;

   // free address decode
   assign diff          = {1'b0, addr_ff} - {1'b0, pool_base_ff};
   assign outside       = diff[32] || (diff[31:HI_LO] >= HI_W'(NUM_WORDS));
   assign free_word     = diff[HI_LO +: WW];
   assign free_addr_bit = diff[BUF_SIZE_LOG2 +: BIT_IDX_W];

   assign cur_word = rd_live_ff ? rd_data_ff : '0;

   // lowest clear bit of the current word
   always_comb begin
      claim_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!cur_word[i]) begin
            claim_bit = BIT_IDX_W'(i);
         end
      end
   end

   assign grant_off = 32'({rd_idx_ff, claim_bit}) << BUF_SIZE_LOG2;
   assign granted   = pool_base_ff + grant_off;

   always_comb begin
      rd_addr = rd_idx_ff + WW'(1);
      if (cmd.rd_free) begin
         rd_addr = free_word;
      end else if (cmd.rd_first) begin
         rd_addr = '0;
      end
   end

   assign rd_en   = cmd.rd_free || cmd.rd_first || cmd.rd_next;
   assign wr_en   = cmd.claim || cmd.free_wr;
   assign wr_data = cmd.claim ? (cur_word | (32'b1 << claim_bit))
                              : (cur_word & ~(32'b1 << free_addr_bit));

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= use_mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
      if (wr_en) begin
         use_mem[rd_idx_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
         rd_live_ff    <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_live_ff <= word_valid_ff[rd_addr];
         end
         if (wr_en) begin
            word_valid_ff[rd_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_op;
         req_bytes_ff <= req_request_bytes;
         addr_ff      <= req_buffer_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
      end else if (csr_write) begin
         pool_base_ff <= csr_pool_base;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_status_ff  <= ST_OK;
         res_granted_ff <= '0;
      end else begin
         if (cmd.set_status) begin
            res_status_ff <= cmd.status_code;
         end
         if (cmd.claim) begin
            res_granted_ff <= granted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_granted_ff <= res_granted_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;

   assign sts.is_free_op    = (op_ff == OP_FREE);
   assign sts.too_large     = (32'(req_bytes_ff) > (32'd1 << BUF_SIZE_LOG2));
   assign sts.outside       = outside;
   assign sts.word_has_free = (cur_word != '1);
   assign sts.last_word     = (rd_idx_ff == WW'(NUM_WORDS - 1));
   assign sts.out_slot_free = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== src/fixed_buffer_bitmap_allocator.sv =====
`timescale 1ns / 1ps

// Fixed-size buffer pool allocator: NUM_WORDS*32 buffers of 2^BUF_SIZE_LOG2 bytes
// starting at pool_base, tracked by a use bitmap kept in a word-wide memory that
// is read one word per cycle. An allocate scans the bitmap words from word 0
// until it finds a free bit, or reports a full pool after the last word. A free
// reads the addressed word and clears its bit, and a rejected transaction (too
// large, outside the pool) goes straight to the result. The bitmap memory
// read port sets the scan speed. The bitmap is empty right out of reset (per-word
// valid bits, no clearing pass). A finished result sits in an output register,
// so the next request is accepted while the response is still stalled.
module fixed_buffer_bitmap_allocator #(
   parameter int NUM_WORDS     = fbba_pkg::NUM_WORDS_DEF,
   parameter int BUF_SIZE_LOG2 = fbba_pkg::BUF_SIZE_LOG2_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_request_bytes,
   input  logic [31:0] req_buffer_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_granted_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_pool_base
);
   import fbba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   fbba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbba_datapath #(
      .NUM_WORDS     (NUM_WORDS),
      .BUF_SIZE_LOG2 (BUF_SIZE_LOG2)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_op              (req_op),
      .req_request_bytes   (req_request_bytes),
      .req_buffer_address  (req_buffer_address),
      .csr_write           (csr_valid && csr_ready),
      .csr_pool_base       (csr_pool_base),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .cmd                 (cmd),
      .sts                 (sts)
   );

`ifndef SYNTHESIS
   // a transaction in flight blocks the input side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous transaction in flight");

   // only a successful allocate carries an address
   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_granted_address == 32'd0))
      else $error("failed transaction reports a nonzero address");

   // a result never appears in the cycle right after acceptance
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("response raised too early");
`endif

endmodule
